// File: src/mbwc_pkg.sv
// ----------------------------------------------------------------------------
// mbwc_pkg
// shared widths, register indexes, config record and raster op function for
// the monochrome blitter word combiner
// ----------------------------------------------------------------------------
package mbwc_pkg;

   localparam int WORD_BITS  = 16;
   localparam int SHIFT_BITS = $clog2(WORD_BITS);
   localparam int OP_BITS    = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 4;

   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [SHIFT_BITS-1:0]    nib_type;
   typedef logic [OP_BITS-1:0]       op_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // register indexes
   localparam csr_idx_type REG_ALIGN_SHIFT = 2'd0;
   localparam csr_idx_type REG_FIRST_BIT   = 2'd1;
   localparam csr_idx_type REG_END_BITS    = 2'd2;
   localparam csr_idx_type REG_RASTER_OP   = 2'd3;

   // raster op codes that matter for reset and comments
   localparam op_type ROP_ZERO   = 4'd0;
   localparam op_type ROP_SOURCE = 4'd3;

   localparam word_type WORD_ONES = '1;

   typedef struct packed {
      nib_type align_shift;
      nib_type first_bit;
      nib_type end_bits;
      op_type  raster_op;
   } cfg_type;

   // per-bit truth table: op bit 0 s&d, bit 1 s&~d, bit 2 ~s&d, bit 3 ~s&~d
   function automatic word_type raster_op_apply(op_type op, word_type s, word_type d);
      word_type r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         r[i] = op[{~s[i], ~d[i]}];
      end
      return r;
   endfunction

endpackage

// File: src/mbwc_if.sv
// ----------------------------------------------------------------------------
// mbwc channel interfaces
// valid/ready channels for source/destination words, result words and
// register writes
// ----------------------------------------------------------------------------
interface mbwc_req_if import mbwc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type src_word;
   word_type dst_word;
   logic     prime;
   logic     row_first;
   logic     row_last;

   modport source (output valid, src_word, dst_word, prime, row_first, row_last,
                   input ready);
   modport sink   (input valid, src_word, dst_word, prime, row_first, row_last,
                   output ready);
endinterface

interface mbwc_rsp_if import mbwc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type out_word;
   logic     out_row_end;

   modport source (output valid, out_word, out_row_end, input ready);
   modport sink   (input valid, out_word, out_row_end, output ready);
endinterface

interface mbwc_csr_if import mbwc_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  reg_index;
   csr_data_type wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: src/mbwc_csr_regs.sv
// ----------------------------------------------------------------------------
// mbwc_csr_regs
// configuration register file, written one register per transfer
// ----------------------------------------------------------------------------
module mbwc_csr_regs import mbwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   mbwc_csr_if.sink csr_bus,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            REG_ALIGN_SHIFT: cfg_in.align_shift = csr_bus.wr_data;
            REG_FIRST_BIT:   cfg_in.first_bit   = csr_bus.wr_data;
            REG_END_BITS:    cfg_in.end_bits    = csr_bus.wr_data;
            REG_RASTER_OP:   cfg_in.raster_op   = csr_bus.wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.align_shift <= '0;
         cfg_ff.first_bit   <= '0;
         cfg_ff.end_bits    <= '0;
         cfg_ff.raster_op   <= ROP_SOURCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/mbwc_word_path.sv
// ----------------------------------------------------------------------------
// mbwc_word_path
// funnel shift, raster op and edge masking for one destination word
// ----------------------------------------------------------------------------
module mbwc_word_path import mbwc_pkg::*; (
   input  cfg_type  cfg,
   input  word_type held_word,
   input  word_type src_word,
   input  word_type dst_word,
   input  logic     row_first,
   input  logic     row_last,
   output word_type out_word
);

   logic [2*WORD_BITS-1:0] joined;
   logic [2*WORD_BITS-1:0] shifted;
   word_type aligned;
   word_type rop_word;
   word_type begin_mask;
   word_type end_mask;
   word_type mask;

   always_comb begin
      joined  = {held_word, src_word};
      shifted = joined >> cfg.align_shift;
      aligned = shifted[WORD_BITS-1:0];

      rop_word = raster_op_apply(cfg.raster_op, aligned, dst_word);

      begin_mask = row_first ? (WORD_ONES >> cfg.first_bit) : WORD_ONES;
      // zero end count means the last word is used in full
      end_mask   = (row_last && (cfg.end_bits != '0))
                   ? ~(WORD_ONES >> cfg.end_bits) : WORD_ONES;
      mask       = begin_mask & end_mask;

      out_word = (rop_word & mask) | (dst_word & ~mask);
   end

endmodule

// File: src/mono_bitblt_word_combiner.sv
// ----------------------------------------------------------------------------
// mono_bitblt_word_combiner
// word datapath of a 1 bit per pixel blitter: funnel shift, raster op, edges
// ----------------------------------------------------------------------------
// One destination word per clock. Each transfer on req_bus brings a source
// and a destination word; the source is aligned by a right funnel shift over
// the held previous source word, combined with the destination by one of 16
// raster ops and merged back under the begin and end edge masks. The result
// appears on rsp_bus in the cycle after the transfer and sits in a single output
// register; req_bus stays ready as long as that register is empty or is being
// taken in the same cycle, so with rsp_bus ready the block takes a word every
// clock. A prime transfer only loads the held source word and gives no
// result; a row_last transfer clears the held word after use. Registers are
// written through csr_bus (always ready) and must only change while no word is
// in flight.
// ----------------------------------------------------------------------------
module mono_bitblt_word_combiner import mbwc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mbwc_req_if.sink   req_bus,
   mbwc_rsp_if.source rsp_bus,
   mbwc_csr_if.sink   csr_bus
);

   cfg_type  cfg;
   word_type path_word;

   // held source word for the funnel shift
   word_type held_ff, held_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_word_ff, rsp_word_in;
   logic     rsp_row_end_ff, rsp_row_end_in;

   logic req_fire;
   logic rsp_fire;
   logic word_fire;

   mbwc_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mbwc_word_path u_path (
      .cfg       (cfg),
      .held_word (held_ff),
      .src_word  (req_bus.src_word),
      .dst_word  (req_bus.dst_word),
      .row_first (req_bus.row_first),
      .row_last  (req_bus.row_last),
      .out_word  (path_word)
   );

   // output register empty or draining this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;
   // transfer that produces a result word
   assign word_fire     = req_fire && !req_bus.prime;

   always_comb begin
      held_in = held_ff;
      if (req_fire) begin
         // a row end clears the carry so the next row starts clean
         if (!req_bus.prime && req_bus.row_last) begin
            held_in = '0;
         end else begin
            held_in = req_bus.src_word;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_row_end_in = rsp_row_end_ff;
      if (word_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_word_in    = path_word;
         rsp_row_end_in = req_bus.row_last;
      end else if (rsp_fire) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_word_ff    <= rsp_word_in;
      rsp_row_end_ff <= rsp_row_end_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_word    = rsp_word_ff;
   assign rsp_bus.out_row_end = rsp_row_end_ff;

   // held word is empty after a row end
   a_row_end_clears_held: assert property (@(posedge clock) disable iff (reset)
      word_fire && req_bus.row_last |=> held_ff == '0)
      else $error("held source not cleared after row end");

   // every non-prime transfer leaves a result pending
   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      word_fire |=> rsp_valid_ff)
      else $error("result missing after word transfer");

   // a prime transfer never creates a result
   a_prime_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.prime && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("prime transfer produced a result");

   // row end flag follows the transfer that made the word
   a_row_end_tracks: assert property (@(posedge clock) disable iff (reset)
      word_fire |=> rsp_row_end_ff == $past(req_bus.row_last))
      else $error("row end flag mismatch");

endmodule
